[sv/polar_ray_segment_hit_test_defines.svh]
// Assertion macros shared by the ray/segment hit-test RTL.
`ifndef POLAR_RAY_SEGMENT_HIT_TEST_DEFINES_SVH
`define POLAR_RAY_SEGMENT_HIT_TEST_DEFINES_SVH
`ifndef SYNTHESIS
`define PRT_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("prt assertion failed");
`define PRT_ASSERT(lbl, prop) `PRT_ASSERT_CLK(lbl, clk_i, rst_ni, prop)
`else
`define PRT_ASSERT_CLK(lbl, clk, rstn, prop)
`define PRT_ASSERT(lbl, prop)
`endif
`endif

[sv/prt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prt_pkg
// Constants, types and the arctangent table of the ray/segment hit test.
// ----------------------------------------------------------------------------
package prt_pkg;

  localparam int ANGLE_BITS    = 16;
  localparam int COORD_BITS    = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int DW            = 36;   // CORDIC datapath width
  localparam int ZW            = 32;   // internal angle width
  localparam int SHW           = 5;    // shift amount width

  localparam logic [29:0]   KQ30      = 30'd652032874;
  localparam logic [ZW-1:0] HALF_TURN = 32'h8000_0000;

  typedef struct packed {
    logic                  cmd;
    logic [ANGLE_BITS-1:0] head;
    logic signed [COORD_BITS-1:0] lx;
    logic signed [COORD_BITS-1:0] ly;
    logic signed [DW-1:0]  rx;
    logic signed [DW-1:0]  ry;
    logic [ZW-1:0]         rz;
    logic signed [DW-1:0]  ax;
    logic signed [DW-1:0]  ay;
    logic [ZW-1:0]         az;
    logic                  a_zero;
    logic signed [DW-1:0]  bx;
    logic signed [DW-1:0]  by;
    logic [ZW-1:0]         bz;
    logic                  b_zero;
  } prt_work_t;

  function automatic logic [ZW-1:0] atan_lut(input logic [SHW-1:0] k);
    logic [ZW-1:0] v;
    case (k)
      5'd0:  v = 32'h20000000;  5'd1:  v = 32'h12E4051D;
      5'd2:  v = 32'h09FB385B;  5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;  5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;  5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;  5'd9:  v = 32'h00145F2E;
      5'd10: v = 32'h000A2F98;  5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;  5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2F9;  5'd15: v = 32'h0000517C;
      5'd16: v = 32'h000028BE;  5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A2F;  5'd19: v = 32'h00000517;
      5'd20: v = 32'h0000028B;  5'd21: v = 32'h00000145;
      5'd22: v = 32'h000000A2;  5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000028;  5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;  5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000002;  5'd29: v = 32'h00000001;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[sv/prt_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prt_in_if
// Query channel: one ray and one segment per word.
// ----------------------------------------------------------------------------
interface prt_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [15:0] heading;
  logic [23:0] reach;
  logic signed [15:0] seg_x;
  logic signed [15:0] seg_y;
  logic [14:0] seg_len;

  modport source (output valid, command, heading, reach, seg_x, seg_y, seg_len,
                  input ready);
  modport sink   (input valid, command, heading, reach, seg_x, seg_y, seg_len,
                  output ready);
endinterface

[sv/prt_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prt_out_if
// Result channel: one hit flag per word.
// ----------------------------------------------------------------------------
interface prt_out_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink   (input valid, hit, output ready);
endinterface

[sv/prt_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prt_cell
// One CORDIC iteration: a rotation step for the ray and vectoring steps
// for both segment endpoints, registered.
// ----------------------------------------------------------------------------
module prt_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic [prt_pkg::SHW-1:0] shift_i,
  input  logic                valid_i,
  input  prt_pkg::prt_work_t  data_i,
  output logic                valid_o,
  output prt_pkg::prt_work_t  data_o
);
  import prt_pkg::*;

  logic          valid_q;
  prt_work_t     data_q, data_d;
  logic [ZW-1:0] atan;

  assign atan = atan_lut(shift_i);

  always_comb begin
    data_d = data_i;
    // Ray rotation, counterclockwise while the remaining angle is >= 0.
    if (!data_i.rz[ZW-1]) begin
      data_d.rx = data_i.rx - (data_i.ry >>> shift_i);
      data_d.ry = data_i.ry + (data_i.rx >>> shift_i);
      data_d.rz = data_i.rz - atan;
    end else begin
      data_d.rx = data_i.rx + (data_i.ry >>> shift_i);
      data_d.ry = data_i.ry - (data_i.rx >>> shift_i);
      data_d.rz = data_i.rz + atan;
    end
    // Endpoint vectoring drives y toward zero.
    if (!data_i.ay[DW-1]) begin
      data_d.ax = data_i.ax + (data_i.ay >>> shift_i);
      data_d.ay = data_i.ay - (data_i.ax >>> shift_i);
      data_d.az = data_i.az + atan;
    end else begin
      data_d.ax = data_i.ax - (data_i.ay >>> shift_i);
      data_d.ay = data_i.ay + (data_i.ax >>> shift_i);
      data_d.az = data_i.az - atan;
    end
    if (!data_i.by[DW-1]) begin
      data_d.bx = data_i.bx + (data_i.by >>> shift_i);
      data_d.by = data_i.by - (data_i.bx >>> shift_i);
      data_d.bz = data_i.bz + atan;
    end else begin
      data_d.bx = data_i.bx - (data_i.by >>> shift_i);
      data_d.by = data_i.by + (data_i.bx >>> shift_i);
      data_d.bz = data_i.bz - atan;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[sv/polar_ray_segment_hit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polar_ray_segment_hit_test
// Tests whether a ray from the origin reaches an axis-aligned segment.
// ----------------------------------------------------------------------------
// Usage:
//   A query word on in_i carries the ray heading and reach and a segment
//   (start point, length, horizontal or vertical). One result word with
//   the hit flag leaves on out_o for each query, in order.
//   A word is moved when valid and ready are both high.
//   The front stage scales the reach by the CORDIC gain; a row of 16
//   identical cells then rotates the ray and vectors both segment ends,
//   one CORDIC iteration per cell; the last stage decides the hit.
//   The block takes one query every cycle while out_o is not stalled,
//   set by the one-iteration-per-cell row.
//   When the receiver stalls, the whole row holds and in_i.ready drops
//   until the output register is taken; no word is lost.
//   Reset empties the row and the output register; no clearing pass.
// ----------------------------------------------------------------------------
`include "polar_ray_segment_hit_test_defines.svh"

module polar_ray_segment_hit_test (
  input  logic          clk_i,
  input  logic          rst_ni,
  prt_in_if.sink        in_i,
  prt_out_if.source     out_o
);
  import prt_pkg::*;

  localparam int EW = COORD_BITS + 1;   // endpoint coordinate width

  logic en;
  assign en       = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  // Front stage: gain-scaled reach and prepared endpoint vectors.
  logic      pv_q;
  prt_work_t pd_q, pd_d;
  logic [53:0] prod;
  logic signed [EW-1:0] ax0, ay0, bx0, by0;
  logic signed [EW-1:0] lx_e, ly_e, len_e;

  assign prod  = 54'(in_i.reach) * 54'(KQ30);
  assign lx_e  = EW'(in_i.seg_x);
  assign ly_e  = EW'(in_i.seg_y);
  assign len_e = EW'({1'b0, in_i.seg_len});

  always_comb begin
    ax0 = lx_e;
    ay0 = ly_e;
    bx0 = in_i.command ? lx_e : lx_e + len_e;
    by0 = in_i.command ? ly_e + len_e : ly_e;
    pd_d        = '0;
    pd_d.cmd    = in_i.command;
    pd_d.head   = in_i.heading[ANGLE_BITS-1:0];
    pd_d.lx     = in_i.seg_x;
    pd_d.ly     = in_i.seg_y;
    pd_d.rx     = DW'(prod[53:22]);
    pd_d.ry     = '0;
    pd_d.rz     = {in_i.heading[ANGLE_BITS-1:0], {(ZW-ANGLE_BITS){1'b0}}};
    pd_d.a_zero = (ax0 == '0) && (ay0 == '0);
    pd_d.b_zero = (bx0 == '0) && (by0 == '0);
    if (ax0 < 0) begin
      pd_d.ax = DW'(-ax0) <<< 16;
      pd_d.ay = DW'(-ay0) <<< 16;
      pd_d.az = HALF_TURN;
    end else begin
      pd_d.ax = DW'(ax0) <<< 16;
      pd_d.ay = DW'(ay0) <<< 16;
      pd_d.az = '0;
    end
    if (bx0 < 0) begin
      pd_d.bx = DW'(-bx0) <<< 16;
      pd_d.by = DW'(-by0) <<< 16;
      pd_d.bz = HALF_TURN;
    end else begin
      pd_d.bx = DW'(bx0) <<< 16;
      pd_d.by = DW'(by0) <<< 16;
      pd_d.bz = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else if (en) begin
      pv_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pd_q <= pd_d;
    end
  end

  // Second or third quadrant: turn the ray by half a turn first.
  prt_work_t cd [CORDIC_STAGES+1];
  logic [CORDIC_STAGES:0] cv;

  always_comb begin
    cd[0] = pd_q;
    if (pd_q.rz[ZW-1] ^ pd_q.rz[ZW-2]) begin
      cd[0].rx = -pd_q.rx;
      cd[0].rz = pd_q.rz - HALF_TURN;
    end
  end
  assign cv[0] = pv_q;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    prt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .shift_i (SHW'(g)),
      .valid_i (cv[g]),
      .data_i  (cd[g]),
      .valid_o (cv[g+1]),
      .data_o  (cd[g+1])
    );
  end

  // Hit decision.
  prt_work_t fd;
  logic [ZW-1:0] a_rnd, b_rnd;
  logic [ANGLE_BITS-1:0] a_ang, b_ang, la, ra;
  logic signed [DW-1:0] line, pos;
  logic line_neg, reached, arc, hit_d;
  logic out_v_q, hit_q;

  assign fd = cd[CORDIC_STAGES];

  always_comb begin
    a_rnd = fd.az + (ZW'(1) << (ZW - ANGLE_BITS - 1));
    b_rnd = fd.bz + (ZW'(1) << (ZW - ANGLE_BITS - 1));
    a_ang = fd.a_zero ? '0 : a_rnd[ZW-1 -: ANGLE_BITS];
    b_ang = fd.b_zero ? '0 : b_rnd[ZW-1 -: ANGLE_BITS];
    if (fd.cmd) begin
      line_neg = fd.lx[COORD_BITS-1];
      line     = DW'(fd.lx) <<< 16;
      pos      = fd.rx;
      la       = line_neg ? b_ang : a_ang;
      ra       = line_neg ? a_ang : b_ang;
    end else begin
      line_neg = fd.ly[COORD_BITS-1];
      line     = DW'(fd.ly) <<< 16;
      pos      = fd.ry;
      la       = line_neg ? a_ang : b_ang;
      ra       = line_neg ? b_ang : a_ang;
    end
    reached = line_neg ? (pos <= line) : (pos >= line);
    if (la <= ra) begin
      arc = (la <= fd.head) && (fd.head <= ra);
    end else begin
      arc = (la <= fd.head) || (fd.head <= ra);
    end
    hit_d = reached && arc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= cv[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q <= hit_d;
    end
  end

  assign out_o.valid = out_v_q;
  assign out_o.hit   = hit_q;

  `PRT_ASSERT(a_accept_enters_front, (in_i.valid && in_i.ready) |=> pv_q)
  `PRT_ASSERT(a_front_enters_row, (pv_q && en) |=> cv[1])
  `PRT_ASSERT(a_row_frozen_on_stall, !en |=> $stable(cv))
  `PRT_ASSERT(a_last_cell_to_output, (cv[CORDIC_STAGES] && en) |=> out_o.valid)

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Regression for the ray/segment hit test: a model of the CORDIC hit
// decision predicts each result word, which is compared in order.
// ----------------------------------------------------------------------------
module testbench;
  import prt_pkg::*;

  typedef struct packed {
    logic                    command;
    logic [15:0]             heading;
    logic [23:0]             reach;
    logic signed [15:0]      seg_x;
    logic signed [15:0]      seg_y;
    logic [14:0]             seg_len;
  } query_t;

  localparam longint unsigned KGAIN = 64'd652032874;
  localparam logic [31:0] HALF = 32'h8000_0000;
  localparam int CYCLE_LIMIT = 400000;

  logic clk_i;
  logic rst_ni;
  prt_in_if  qry ();
  prt_out_if res ();

  polar_ray_segment_hit_test dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (qry.sink),
    .out_o (res.source)
  );

  query_t pending_q[$];
  logic   expected_hits[$];
  int     idle_pct;
  int     stall_pct;
  bit     failed;
  int     cycles;
  bit     in_taken;

  always begin
    clk_i = 1'b1; #6;
    clk_i = 1'b0; #6;
  end

  function automatic logic [31:0] atan_step(int k);
    logic [31:0] tab [16] = '{
      32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C};
    return tab[k];
  endfunction

  // Angle of a point in 16-bit angle units; the origin maps to zero.
  function automatic logic [15:0] point_angle(longint px, longint py);
    longint      x;
    longint      y;
    longint      dx;
    longint      dy;
    logic [31:0] z;
    if (px == 0 && py == 0) return 16'd0;
    x = px * 65536;
    y = py * 65536;
    z = '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = HALF;
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_step(i);
      end else begin
        x -= dx; y += dy; z -= atan_step(i);
      end
    end
    z = z + 32'h0000_8000;
    return z[31:16];
  endfunction

  function automatic logic predict_hit(query_t q);
    longint      x;
    longint      y;
    longint      dx;
    longint      dy;
    longint      lx;
    longint      ly;
    longint      line_pos;
    logic [31:0] z;
    logic [15:0] a0;
    logic [15:0] a1;
    logic [15:0] left;
    logic [15:0] right;
    lx = q.seg_x;
    ly = q.seg_y;
    z = {q.heading, 16'h0};
    x = longint'((longint'(q.reach) * KGAIN) >> 22);
    y = 0;
    if (z[31:30] == 2'b01 || z[31:30] == 2'b10) begin
      x = -x;
      z = z - HALF;
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (!z[31]) begin
        x -= dx; y += dy; z -= atan_step(i);
      end else begin
        x += dx; y -= dy; z += atan_step(i);
      end
    end
    if (!q.command) begin
      line_pos = ly * 65536;
      if ((ly >= 0 && y < line_pos) || (ly < 0 && y > line_pos)) return 1'b0;
      a0 = point_angle(lx, ly);
      a1 = point_angle(lx + q.seg_len, ly);
      if (ly >= 0) begin left = a1; right = a0; end
      else begin left = a0; right = a1; end
    end else begin
      line_pos = lx * 65536;
      if ((lx >= 0 && x < line_pos) || (lx < 0 && x > line_pos)) return 1'b0;
      a0 = point_angle(lx, ly);
      a1 = point_angle(lx, ly + q.seg_len);
      if (lx >= 0) begin left = a0; right = a1; end
      else begin left = a1; right = a0; end
    end
    if (left <= right) return left <= q.heading && q.heading <= right;
    return q.heading >= left || q.heading <= right;
  endfunction

  function automatic query_t random_query();
    query_t q;
    int     mode;
    q = query_t'(88'({$urandom, $urandom, $urandom}));
    mode = $urandom_range(0, 9);
    // Most queries place a reachable segment near the ray so both
    // outcomes of the arc test occur often.
    if (mode < 7) begin
      q.reach = 24'($urandom_range(0, 1 << 20));
      q.seg_x = $signed(16'($urandom_range(0, 8000))) - 16'sd4000;
      q.seg_y = $signed(16'($urandom_range(0, 8000))) - 16'sd4000;
      q.seg_len = 15'($urandom_range(0, 6000));
    end else if (mode < 9) begin
      q.seg_x = $signed(16'($urandom_range(0, 64))) - 16'sd32;
      q.seg_y = $signed(16'($urandom_range(0, 64))) - 16'sd32;
      q.seg_len = 15'($urandom_range(0, 64));
      q.reach = 24'($urandom_range(0, 1 << 14));
    end
    return q;
  endfunction

  function automatic query_t make_query(logic c, logic [15:0] h, logic [23:0] r,
                                        int sx, int sy, int sl);
    query_t q;
    q.command = c;
    q.heading = h;
    q.reach = r;
    q.seg_x = 16'(sx);
    q.seg_y = 16'(sy);
    q.seg_len = 15'(sl);
    return q;
  endfunction

  // Remembers whether the query word was taken at the last rising edge.
  always @(posedge clk_i) begin
    in_taken <= qry.valid && qry.ready;
  end

  // Query driver: presents words at the falling edge.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) void'(pending_q.pop_front());
      if (pending_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        qry.valid <= 1'b1;
        {qry.command, qry.heading, qry.reach, qry.seg_x, qry.seg_y, qry.seg_len}
          <= pending_q[0];
      end else begin
        qry.valid <= 1'b0;
      end
      res.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Monitor: predicts on acceptance and checks results at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycles <= cycles + 1;
      if (qry.valid && qry.ready)
        expected_hits.push_back(predict_hit(query_t'({qry.command, qry.heading,
          qry.reach, qry.seg_x, qry.seg_y, qry.seg_len})));
      if (res.valid && res.ready) begin
        if (expected_hits.size() == 0) begin
          $display("%0t: unexpected result word, hit %0b", $time, res.hit);
          failed <= 1'b1;
        end else begin
          if (res.hit !== expected_hits[0]) begin
            $display("%0t: hit mismatch, expected %0b actual %0b",
                     $time, expected_hits[0], res.hit);
            failed <= 1'b1;
          end
          void'(expected_hits.pop_front());
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("polar_ray_segment_hit_test regression: fail");
      $finish;
    end
  end

  task automatic run_phase(int idle, int stall, int count);
    idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < count; i++) pending_q.push_back(random_query());
    wait (pending_q.size() == 0 && !qry.valid);
  endtask

  initial begin
    failed = 1'b0;
    cycles = 0;
    idle_pct = 0;
    stall_pct = 0;
    rst_ni = 1'b0;
    qry.valid = 1'b0;
    qry.command = 1'b0;
    qry.heading = '0;
    qry.reach = '0;
    qry.seg_x = '0;
    qry.seg_y = '0;
    qry.seg_len = '0;
    res.ready = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed words: field extremes, both segment kinds, both sides of
    // the origin, endpoints at the origin and arcs that wrap past zero.
    pending_q.push_back(make_query(1'b0, 16'h0000, 24'h000000, 0, 0, 0));
    pending_q.push_back(make_query(1'b1, 16'hFFFF, 24'hFFFFFF, 32767, 32767, 32767));
    pending_q.push_back(make_query(1'b0, 16'h4000, 24'hFFFFFF, -32768, 100, 32767));
    pending_q.push_back(make_query(1'b0, 16'hC000, 24'hFFFFFF, -32768, -100, 32767));
    pending_q.push_back(make_query(1'b1, 16'h0000, 24'hFFFFFF, 100, -32768, 32767));
    pending_q.push_back(make_query(1'b1, 16'h8000, 24'hFFFFFF, -100, -32768, 32767));
    pending_q.push_back(make_query(1'b1, 16'h0000, 24'h006400, 100, -10, 20));
    pending_q.push_back(make_query(1'b1, 16'h0000, 24'h0063FF, 100, -10, 20));
    pending_q.push_back(make_query(1'b0, 16'h4000, 24'h006400, -10, 100, 20));
    pending_q.push_back(make_query(1'b0, 16'h0000, 24'h001000, 0, 0, 50));
    pending_q.push_back(make_query(1'b1, 16'h0000, 24'h001000, 0, 0, 50));
    pending_q.push_back(make_query(1'b1, 16'hFFF0, 24'h010000, 50, -10, 20));
    pending_q.push_back(make_query(1'b1, 16'h0010, 24'h010000, 50, -10, 20));
    pending_q.push_back(make_query(1'b0, 16'h8000, 24'h800000, -32768, -32768, 0));
    pending_q.push_back(make_query(1'b0, 16'h2000, 24'h004000, 10, 10, 0));
    pending_q.push_back(make_query(1'b1, 16'hE000, 24'h004000, 10, -10, 0));
    pending_q.push_back(make_query(1'b0, 16'h6000, 24'h7FFFFF, -200, 200, 400));
    pending_q.push_back(make_query(1'b1, 16'hA000, 24'h7FFFFF, -200, -200, 400));
    wait (pending_q.size() == 0 && !qry.valid);

    run_phase(0, 0, 400);
    run_phase(58, 0, 400);
    run_phase(0, 58, 400);
    run_phase(12, 12, 400);

    stall_pct = 0;
    wait (expected_hits.size() == 0);
    repeat (40) @(posedge clk_i);
    if (!failed && expected_hits.size() == 0) begin
      $display("polar_ray_segment_hit_test regression: pass");
    end else begin
      $display("polar_ray_segment_hit_test regression: fail");
    end
    $finish;
  end
endmodule
